// ===== hw/rtl/chain_counter_with_endstops_unit_macros.svh =====
// Assertion macros used by the chain counter core RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef CHAIN_COUNTER_WITH_ENDSTOPS_UNIT_MACROS_SVH
`define CHAIN_COUNTER_WITH_ENDSTOPS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CCWE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chain counter check failed");

// Next-cycle implication, disabled during reset
`define CCWE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chain counter check failed");

`endif

// ===== hw/rtl/ccwe_pkg.sv =====
// Shared types and codes for the chain counter with endstops.
// No dependencies; used by the core, the top level and the testbench.
package ccwe_pkg;

   // CSR port geometry
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;
   localparam int LIMIT_W    = 15;
   localparam int OUT_CNT_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_QUAD_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LIMIT = 1'd1;

   // Command codes
   localparam logic [2:0] CMD_STOP      = 3'd0;
   localparam logic [2:0] CMD_UP        = 3'd1;
   localparam logic [2:0] CMD_DOWN      = 3'd2;
   localparam logic [2:0] CMD_FORCE_UP  = 3'd3;
   localparam logic [2:0] CMD_FORCE_DWN = 3'd4;

   // Drive codes as seen on the result channel
   typedef enum logic [1:0] {
      DRV_STOP = 2'd0,
      DRV_UP   = 2'd1,
      DRV_DOWN = 2'd2,
      DRV_ERR  = 2'd3
   } drive_type;

   typedef struct packed {
      logic       action;
      logic       enc_a;
      logic       enc_b;
      logic [2:0] command;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                  drive;
      logic signed [OUT_CNT_W-1:0] chain_count;
      logic                        forced;
   } rsp_item_type;

   typedef struct packed {
      logic               quad_mode;
      logic [LIMIT_W-1:0] count_limit;
   } cfg_type;

endpackage

// ===== hw/rtl/ccwe_req_if.sv =====
// Request channel of the chain counter: valid/ready plus one input item.
// Depends on nothing but the handshake convention.
interface ccwe_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic       enc_a;
   logic       enc_b;
   logic [2:0] command;

   modport source (output valid, action, enc_a, enc_b, command, input ready);
   modport sink   (input valid, action, enc_a, enc_b, command, output ready);
endinterface

// ===== hw/rtl/ccwe_rsp_if.sv =====
// Response channel of the chain counter: valid/ready plus one result item.
// Depends on nothing but the handshake convention.
interface ccwe_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         drive;
   logic signed [15:0] chain_count;
   logic               forced;

   modport source (output valid, drive, chain_count, forced, input ready);
   modport sink   (input valid, drive, chain_count, forced, output ready);
endinterface

// ===== hw/rtl/ccwe_core.sv =====
// Counter state and per-item update: encoder decode, saturation, endstops.
// Depends on ccwe_pkg and the assertion macro header.
`include "chain_counter_with_endstops_unit_macros.svh"

module ccwe_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  ccwe_pkg::req_item_type item,
   input  ccwe_pkg::cfg_type      cfg,
   output ccwe_pkg::rsp_item_type result
);
   import ccwe_pkg::*;

   localparam int CMP_W = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 1;
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   logic signed [COUNT_WIDTH-1:0] count_ff, count_in, stepped, check_cnt;
   logic                          prev_a_ff, prev_a_in, prev_b_ff, prev_b_in;
   drive_type                     drive_ff, drive_in, dir, cmd_dir;
   logic                          force_ff, force_in, cmd_force;
   logic                          a_edge, b_edge, inc, dec, at_floor, at_ceil, blocked;
   logic signed [CMP_W-1:0]       cnt_ext, lim_ext;

   // Decode encoder edges into a count step
   always_comb begin
      a_edge = item.enc_a ^ prev_a_ff;
      b_edge = item.enc_b ^ prev_b_ff;
      if (cfg.quad_mode) begin
         inc = (a_edge && (item.enc_a == item.enc_b)) ||
               (b_edge && (item.enc_a != item.enc_b));
         dec = (a_edge && (item.enc_a != item.enc_b)) ||
               (b_edge && (item.enc_a == item.enc_b));
      end else begin
         inc = a_edge && (drive_ff != DRV_UP) && !item.enc_a;
         dec = a_edge && (drive_ff == DRV_UP) && item.enc_a;
      end
   end

   // Step with saturation at the signed range
   always_comb begin
      stepped = count_ff;
      if (inc && !dec && (count_ff != CNT_MAX)) begin
         stepped = count_ff + COUNT_WIDTH'(1);
      end else if (dec && !inc && (count_ff != CNT_MIN)) begin
         stepped = count_ff - COUNT_WIDTH'(1);
      end
   end

   // Decode drive commands
   always_comb begin
      unique case (item.command)
         CMD_UP: begin
            cmd_dir   = DRV_UP;
            cmd_force = 1'b0;
         end
         CMD_DOWN: begin
            cmd_dir   = DRV_DOWN;
            cmd_force = 1'b0;
         end
         CMD_FORCE_UP: begin
            cmd_dir   = DRV_UP;
            cmd_force = 1'b1;
         end
         CMD_FORCE_DWN: begin
            cmd_dir   = DRV_DOWN;
            cmd_force = 1'b1;
         end
         default: begin
            cmd_dir   = DRV_STOP;
            cmd_force = 1'b0;
         end
      endcase
   end

   // Select next state, then run the endstop check on it
   always_comb begin
      if (item.action) begin
         count_in  = count_ff;
         prev_a_in = prev_a_ff;
         prev_b_in = prev_b_ff;
         force_in  = cmd_force;
         dir       = cmd_dir;
      end else begin
         count_in  = stepped;
         prev_a_in = item.enc_a;
         prev_b_in = item.enc_b;
         force_in  = force_ff;
         dir       = drive_ff;
      end
      check_cnt = count_in;
      cnt_ext   = CMP_W'(check_cnt);
      lim_ext   = $signed(CMP_W'(cfg.count_limit));
      at_floor  = check_cnt[COUNT_WIDTH-1] || (check_cnt == '0);
      at_ceil   = cnt_ext >= lim_ext;
      blocked   = !force_in && (((dir == DRV_UP) && at_floor) ||
                                ((dir == DRV_DOWN) && at_ceil));
      drive_in  = blocked ? DRV_ERR : dir;
   end

   // Result of this item, as the state stands after it
   always_comb begin
      result.drive       = drive_in;
      result.chain_count = OUT_CNT_W'(count_in);
      result.forced      = force_in;
   end

   // Commit state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         prev_a_ff <= 1'b0;
         prev_b_ff <= 1'b0;
         drive_ff  <= DRV_STOP;
         force_ff  <= 1'b0;
      end else if (fire) begin
         count_ff  <= count_in;
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         drive_ff  <= drive_in;
         force_ff  <= force_in;
      end
   end

   `CCWE_ASSERT_NOW(a_forced_moving, clock, reset, force_ff,
      (drive_ff == DRV_UP) || (drive_ff == DRV_DOWN))
   `CCWE_ASSERT_NEXT(a_cmd_holds_count, clock, reset, fire && item.action,
      $stable(count_ff))
   `CCWE_ASSERT_NEXT(a_count_unit_step, clock, reset, fire,
      (count_ff == $past(count_ff)) ||
      (count_ff == $past(count_ff) + COUNT_WIDTH'(1)) ||
      (count_ff == $past(count_ff) - COUNT_WIDTH'(1)))

endmodule

// ===== hw/rtl/chain_counter_with_endstops_unit.sv =====
// Top level of the chain counter with endstops: channels, CSRs, item registers.
// Depends on ccwe_pkg, ccwe_req_if, ccwe_rsp_if and ccwe_core.
//
// Use:
//   req_chan carries one item per handshake: action=0 samples encoder lines
//   enc_a/enc_b, action=1 applies a drive command. rsp_chan returns exactly
//   one result item per request item: drive code, chain count and forced flag.
//   Write quadrature_mode (index 0) and count_limit (index 1) through csr_we,
//   csr_index and csr_wdata while no item is in flight.
// Timing:
//   An accepted item goes to the input register, its result to the result
//   register. One item per cycle is sustained while rsp_chan is not stalled;
//   the ccwe_core update is combinational: each item sees the previous result.
// Reset:
//   Synchronous reset clears both item valid flags, the CSRs, the count, the
//   previous encoder levels, the drive (stopped) and the forced flag.
// Stall:
//   While rsp_chan is stalled the result register holds and one more item can
//   still be taken into the input register; req ready then drops until the
//   result is taken.
module chain_counter_with_endstops_unit #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   ccwe_req_if.sink                           req_chan,
   ccwe_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [ccwe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ccwe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ccwe_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, req_item;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, core_result;
   cfg_type      cfg_ff;
   logic         fire, req_take;

   // Handshake control
   assign fire           = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || fire;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_take || (s1_valid_ff && !fire);
   assign rsp_valid_in   = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      req_item.action  = req_chan.action;
      req_item.enc_a   = req_chan.enc_a;
      req_item.enc_b   = req_chan.enc_b;
      req_item.command = req_chan.command;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the item and the result
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (fire) begin
         rsp_item_ff <= core_result;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUAD_MODE:   cfg_ff.quad_mode   <= csr_wdata[0];
            CSR_COUNT_LIMIT: cfg_ff.count_limit <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   ccwe_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .result(core_result)
   );

   // Drive the result channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.drive       = rsp_item_ff.drive;
   assign rsp_chan.chain_count = rsp_item_ff.chain_count;
   assign rsp_chan.forced      = rsp_item_ff.forced;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for chain_counter_with_endstops_unit: encoder samples and drive commands
// go in, each status item is checked against a cycle-free predictor of the counter.
// Depends on ccwe_pkg, ccwe_req_if, ccwe_rsp_if and the unit's RTL.
module tb;
   import ccwe_pkg::*;

   localparam logic       ACT_SAMPLE      = 1'b0;
   localparam logic       ACT_COMMAND     = 1'b1;
   // Codes past forced down are unused and act as stop
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
   localparam int         COUNT_MAX       = 32767;
   localparam int         COUNT_MIN       = -32768;
   localparam int         QUIET_LIMIT     = 1000;
   localparam int         HOLD_AT         = 300;
   localparam int         HOLD_CYCLES     = 60;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ccwe_req_if req_chan ();
   ccwe_rsp_if rsp_chan ();

   chain_counter_with_endstops_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted counter state and configuration
   logic signed [15:0] pos_count  = '0;
   logic               last_a     = 1'b0;
   logic               last_b     = 1'b0;
   drive_type          drv_state  = DRV_STOP;
   logic               force_on   = 1'b0;
   logic               quad_on    = 1'b0;
   logic [LIMIT_W-1:0] stop_limit = '0;

   req_item_type encoder_items[$];
   rsp_item_type expected_status[$];
   logic         gen_a = 1'b0;
   logic         gen_b = 1'b0;
   logic         idle_on = 1'b1;
   int           mismatch_count = 0;
   int           status_seen = 0;

   // True when an unforced move in this direction runs into an endstop
   function automatic logic endstop_hit(drive_type dir);
      int cnt;
      int lim;
      cnt = int'(pos_count);
      lim = int'(stop_limit);
      return !force_on && ((cnt <= 0 && dir == DRV_UP) || (cnt >= lim && dir == DRV_DOWN));
   endfunction

   function automatic rsp_item_type predict_status(req_item_type it);
      drive_type    dir;
      int           delta;
      int           sum;
      rsp_item_type r;
      if (it.action == ACT_COMMAND) begin
         case (it.command)
            CMD_UP: begin
               dir = DRV_UP;
               force_on = 1'b0;
            end
            CMD_DOWN: begin
               dir = DRV_DOWN;
               force_on = 1'b0;
            end
            CMD_FORCE_UP: begin
               dir = DRV_UP;
               force_on = 1'b1;
            end
            CMD_FORCE_DWN: begin
               dir = DRV_DOWN;
               force_on = 1'b1;
            end
            default: begin
               dir = DRV_STOP;
               force_on = 1'b0;
            end
         endcase
         drv_state = endstop_hit(dir) ? DRV_ERR : dir;
      end else begin
         delta = 0;
         if (quad_on) begin
            if (it.enc_a != last_a) delta += (it.enc_a == it.enc_b) ? 1 : -1;
            if (it.enc_b != last_b) delta += (it.enc_a == it.enc_b) ? -1 : 1;
         end else if (it.enc_a != last_a) begin
            // Reed: paying in counts on rising A, everything else on falling A
            if (drv_state == DRV_UP) delta = it.enc_a ? -1 : 0;
            else delta = it.enc_a ? 0 : 1;
         end
         sum = int'(pos_count);
         sum += delta;
         if (sum > COUNT_MAX) sum = COUNT_MAX;
         if (sum < COUNT_MIN) sum = COUNT_MIN;
         pos_count = sum[15:0];
         last_a = it.enc_a;
         last_b = it.enc_b;
         if (endstop_hit(drv_state)) drv_state = DRV_ERR;
      end
      r.drive = drv_state;
      r.chain_count = pos_count;
      r.forced = force_on;
      return r;
   endfunction

   // Stimulus builders
   task automatic push_sample(input logic a, input logic b);
      req_item_type it;
      it.action = ACT_SAMPLE;
      it.enc_a = a;
      it.enc_b = b;
      it.command = 3'($urandom_range(CMD_STOP, CMD_SPARE_LAST));
      encoder_items.push_back(it);
      gen_a = a;
      gen_b = b;
   endtask

   task automatic push_command(input logic [2:0] code);
      req_item_type it;
      it.action = ACT_COMMAND;
      it.enc_a = 1'($urandom_range(0, 1));
      it.enc_b = 1'($urandom_range(0, 1));
      it.command = code;
      encoder_items.push_back(it);
   endtask

   // Advance one quadrature state: up walks 00 -> 01 -> 11 -> 10
   task automatic push_step(input logic up);
      logic [1:0] phase;
      phase = {gen_a, gen_a ^ gen_b};
      phase = up ? phase + 2'd1 : phase - 2'd1;
      push_sample(phase[1], phase[1] ^ phase[0]);
   endtask

   // Mostly well-formed motion with commands and glitches mixed in
   task automatic queue_random_items(input int n);
      logic heading_up;
      int   pick;
      heading_up = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 12) begin
            push_command(3'($urandom_range(CMD_STOP, CMD_SPARE_LAST)));
         end else if (pick < 20) begin
            push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (quad_on) begin
            if ($urandom_range(0, 3) == 0) heading_up = !heading_up;
            push_step(heading_up);
         end else begin
            push_sample(!gen_a, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic wait_drained;
      do @(negedge clock);
      while (encoder_items.size() != 0 || req_chan.valid || expected_status.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_QUAD_MODE:   quad_on = data[0];
         CSR_COUNT_LIMIT: stop_limit = data[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Reconfigure only once the unit has gone quiet
   task automatic configure(input logic quad, input int limit);
      wait_drained();
      repeat (4) @(posedge clock);
      write_csr(CSR_QUAD_MODE, CSR_DATA_W'(quad));
      write_csr(CSR_COUNT_LIMIT, CSR_DATA_W'(limit));
      @(negedge clock);
   endtask

   // Driver: offer queued items, predict each one as it is taken
   req_item_type offered;
   int           send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_status.push_back(predict_status(offered));
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (encoder_items.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = int'($urandom_range(1, 8)) - 1;
               req_chan.valid <= 1'b0;
            end else begin
               offered = encoder_items.pop_front();
               req_chan.action <= offered.action;
               req_chan.enc_a <= offered.enc_a;
               req_chan.enc_b <= offered.enc_b;
               req_chan.command <= offered.command;
               req_chan.valid <= 1'b1;
            end
         end
      end
   end

   // Monitor: check each status item, stall the result side in bursts
   int   stall_left;
   logic held = 1'b0;

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            status_seen++;
            got.drive = rsp_chan.drive;
            got.chain_count = rsp_chan.chain_count;
            got.forced = rsp_chan.forced;
            if (expected_status.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item: drive %0d count %0d forced %0b",
                        $time, got.drive, got.chain_count, got.forced);
            end else begin
               want = expected_status.pop_front();
               if (got.drive !== want.drive || got.chain_count !== want.chain_count ||
                   got.forced !== want.forced) begin
                  mismatch_count++;
                  $display("%0t: expected drive/count/forced %0d/%0d/%0b, got %0d/%0d/%0b",
                           $time, want.drive, want.chain_count, want.forced,
                           got.drive, got.chain_count, got.forced);
               end
            end
         end
         // Hold off once for a long stretch so the unit backs up into its input
         if (status_seen == HOLD_AT && !held) begin
            held = 1'b1;
            stall_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(1, 8)) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: stop when neither side moves an item for too long
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("chain_counter_with_endstops_unit verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_SAMPLE;
      req_chan.enc_a = 1'b0;
      req_chan.enc_b = 1'b0;
      req_chan.command = CMD_STOP;
      rsp_chan.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reed mode: start-up edge, endstops both ways, forced move, unused codes
      configure(1'b0, 3);
      push_sample(1'b1, 1'b1);
      push_sample(1'b0, 1'b0);
      push_command(CMD_UP);
      push_sample(1'b1, 1'b0);
      push_sample(1'b0, 1'b1);
      push_command(CMD_DOWN);
      push_sample(1'b1, 1'b1);
      push_sample(1'b0, 1'b0);
      push_sample(1'b1, 1'b0);
      push_sample(1'b0, 1'b1);
      push_command(CMD_FORCE_DWN);
      push_sample(1'b1, 1'b0);
      push_sample(1'b0, 1'b0);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         push_command(c[2:0]);

      // Quadrature mode with a zero limit: go negative, block and force up
      configure(1'b1, 0);
      push_command(CMD_STOP);
      repeat (3) push_step(1'b0);
      push_command(CMD_UP);
      push_command(CMD_FORCE_UP);
      repeat (2) push_step(1'b1);
      push_sample(!gen_a, !gen_b);
      push_command(CMD_DOWN);
      push_command(CMD_FORCE_DWN);

      // Sweep past the limit both ways, hitting endstops at the extremes
      configure(1'b1, 20);
      push_command(CMD_STOP);
      repeat (24) push_step(1'b1);
      push_command(CMD_DOWN);
      push_command(CMD_FORCE_UP);
      repeat (48) push_step(1'b0);
      push_command(CMD_UP);
      push_command(CMD_STOP);

      // Random motion under several settings
      configure(1'b1, int'($urandom_range(0, 40)));
      queue_random_items(110);
      configure(1'b0, 0);
      queue_random_items(110);
      configure(1'b0, int'($urandom_range(1, 30)));
      queue_random_items(110);
      configure(1'b0, COUNT_MAX);
      queue_random_items(110);
      configure(1'b1, int'($urandom_range(0, 20)));
      idle_on = 1'b0;
      queue_random_items(110);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("chain_counter_with_endstops_unit verification clean");
      else
         $display("chain_counter_with_endstops_unit verification failed");
      $finish;
   end
endmodule
